@@ sv/slc_pkg.sv @@
// slc_pkg: shared constants, codes and helpers for the set-associative LRU cache model.
// No dependencies; the channel interfaces, the core and the checker all use it.
package slc_pkg;

	localparam int MAX_SETS_DEF = 256;
	localparam int MAX_WAYS_DEF = 8;

	localparam int ADDR_W  = 32;
	localparam int ACT_W   = 2;
	localparam int OUTC_W  = 2;
	localparam int CNT_W   = 32;
	localparam int CIDX_W  = 2;
	localparam int CDATA_W = 5;

	// access kinds
	localparam logic [ACT_W-1:0] ACT_LOAD   = 2'd0;
	localparam logic [ACT_W-1:0] ACT_STORE  = 2'd1;
	localparam logic [ACT_W-1:0] ACT_MODIFY = 2'd2;
	localparam logic [ACT_W-1:0] ACT_NONE   = 2'd3;

	// outcome of the first access
	localparam logic [OUTC_W-1:0] OUTC_HIT   = 2'd0;
	localparam logic [OUTC_W-1:0] OUTC_FILL  = 2'd1;
	localparam logic [OUTC_W-1:0] OUTC_EVICT = 2'd2;

	// register indexes
	localparam logic [CIDX_W-1:0] REG_SET_BITS   = 2'd0;
	localparam logic [CIDX_W-1:0] REG_BLOCK_BITS = 2'd1;
	localparam logic [CIDX_W-1:0] REG_WAYS       = 2'd2;

	// saturating add of a small increment
	function automatic logic [CNT_W-1:0] sat_add(input logic [CNT_W-1:0] v,
			input logic [1:0] inc);
		logic [CNT_W:0] s;
		s = {1'b0, v} + {{(CNT_W-1){1'b0}}, inc};
		return s[CNT_W] ? {CNT_W{1'b1}} : s[CNT_W-1:0];
	endfunction

endpackage

@@ sv/slc_ifs.sv @@
// slc_ifs: valid/ready channel interfaces for access words, result words and register writes.
// Depends on slc_pkg for field widths.
interface slc_req_if;
	logic                         valid;
	logic                         ready;
	logic [slc_pkg::ACT_W-1:0]    action;
	logic [slc_pkg::ADDR_W-1:0]   address;
	modport source(output valid, action, address, input ready);
	modport sink(input valid, action, address, output ready);
endinterface

interface slc_rsp_if;
	logic                         valid;
	logic                         ready;
	logic [slc_pkg::OUTC_W-1:0]   outcome;
	logic                         second_hit;
	logic [slc_pkg::CNT_W-1:0]    total_hits;
	logic [slc_pkg::CNT_W-1:0]    total_misses;
	logic [slc_pkg::CNT_W-1:0]    total_evictions;
	modport source(output valid, outcome, second_hit, total_hits, total_misses,
		total_evictions, input ready);
	modport sink(input valid, outcome, second_hit, total_hits, total_misses,
		total_evictions, output ready);
endinterface

interface slc_cfg_if;
	logic                         valid;
	logic                         ready;
	logic [slc_pkg::CIDX_W-1:0]   index;
	logic [slc_pkg::CDATA_W-1:0]  data;
	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

@@ sv/set_assoc_lru_cache_sim.sv @@
// set_assoc_lru_cache_sim: set-associative LRU cache simulator, one set per memory row.
// Depends on slc_pkg and the channel interfaces in slc_ifs.sv.
//
//  channel | dir | word contents                                         | accepted when
//  --------+-----+-------------------------------------------------------+----------------------
//  req     | in  | action, address                                       | req.valid & req.ready
//  rsp     | out | outcome, second_hit, total_hits/misses/evictions      | rsp.valid & rsp.ready
//  cfg     | in  | index (0 set_bits, 1 block_bits, 2 ways), data        | cfg.valid & cfg.ready
//
// Each access word first reads its set row from the registered set memory; the row is then
// compared, its LRU ranks updated and the row written back.
// After reset and after each write to a known register, a clearing pass sweeps the set
// memory one row a cycle (all MAX_SETS rows) with req.ready low; cfg.ready is always high.
// A result word waits in the output register while the next access word is taken and read;
// its write-back stalls until that result has been taken.
module set_assoc_lru_cache_sim #(
	parameter int MAX_SETS = slc_pkg::MAX_SETS_DEF,
	parameter int MAX_WAYS = slc_pkg::MAX_WAYS_DEF
) (
	input logic        clk,
	input logic        arst_n,
	slc_req_if.sink    req,
	slc_rsp_if.source  rsp,
	slc_cfg_if.sink    cfg
);

	localparam int SIDX_W = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
	localparam int SB_MAX = $clog2(MAX_SETS + 1) - 1;   // largest k with 2^k <= MAX_SETS
	localparam int RK_W   = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
	localparam int WIX_W  = RK_W;
	localparam int NW_W   = ($clog2(MAX_WAYS + 1) > 4) ? $clog2(MAX_WAYS + 1) : 4;

	localparam logic [1:0] ST_CLEAR = 2'd0;
	localparam logic [1:0] ST_IDLE  = 2'd1;
	localparam logic [1:0] ST_LOOK  = 2'd2;

	typedef struct packed {
		logic                       valid;
		logic [RK_W-1:0]            rank;   // 0 most recent, larger older
		logic [slc_pkg::ADDR_W-1:0] tag;
	} line_t;
	typedef line_t [MAX_WAYS-1:0] row_t;

	// configuration
	logic [3:0] set_bits_q;
	logic [4:0] block_bits_q;
	logic [3:0] ways_q;

	logic [1:0]        state_q;
	logic [SIDX_W-1:0] clr_q;

	// stage 1: word under lookup
	logic [slc_pkg::ACT_W-1:0]  act_s1;
	logic [slc_pkg::ADDR_W-1:0] tag_s1;
	logic [SIDX_W-1:0]          set_s1;
	row_t                       row_s1;

	// results
	logic                        rsp_valid_q;
	logic [slc_pkg::OUTC_W-1:0]  outcome_q;
	logic                        second_q;
	logic [slc_pkg::CNT_W-1:0]   hits_q, misses_q, evicts_q;

	row_t set_mem [MAX_SETS];

	// address split
	logic [4:0]                 sb;
	logic [5:0]                 shift;
	logic [slc_pkg::ADDR_W-1:0] set_full;
	logic [SIDX_W-1:0]          set_idx;
	logic [slc_pkg::ADDR_W-1:0] tag_in;

	always_comb begin
		sb = ({1'b0, set_bits_q} > 5'(SB_MAX)) ? 5'(SB_MAX) : {1'b0, set_bits_q};
		shift = {1'b0, sb} + {1'b0, block_bits_q};
		set_full = req.address >> block_bits_q;
		set_idx = set_full[SIDX_W-1:0] & ~({SIDX_W{1'b1}} << sb);
		tag_in = req.address >> shift;
	end

	// handshakes
	logic req_acc, cfg_acc, cfg_hit, look_done;

	assign req.ready = (state_q == ST_IDLE);
	assign cfg.ready = 1'b1;
	assign req_acc   = req.valid && req.ready;
	assign cfg_acc   = cfg.valid && cfg.ready;
	assign cfg_hit   = cfg_acc && (cfg.index == slc_pkg::REG_SET_BITS ||
		cfg.index == slc_pkg::REG_BLOCK_BITS || cfg.index == slc_pkg::REG_WAYS);
	assign look_done = (state_q == ST_LOOK) && (!rsp_valid_q || rsp.ready);

	// lookup and update of the set row
	logic [NW_W-1:0]     ways_ext, nw;
	logic [MAX_WAYS-1:0] active, hit_vec, empty_vec;
	logic [WIX_W-1:0]    hit_way, empty_way, victim, way;
	logic [RK_W-1:0]     oldest, r;
	logic                hit, was_valid;
	row_t                new_row;

	always_comb begin
		ways_ext = NW_W'(ways_q);
		if (ways_q == 4'd0) begin
			nw = NW_W'(1);
		end else if (ways_ext > NW_W'(MAX_WAYS)) begin
			nw = NW_W'(MAX_WAYS);
		end else begin
			nw = ways_ext;
		end
		for (int i = 0; i < MAX_WAYS; i++) begin
			active[i]    = NW_W'(i) < nw;
			hit_vec[i]   = active[i] && row_s1[i].valid && (row_s1[i].tag == tag_s1);
			empty_vec[i] = active[i] && !row_s1[i].valid;
		end
		hit_way   = '0;
		empty_way = '0;
		for (int i = MAX_WAYS - 1; i >= 0; i--) begin
			if (hit_vec[i]) hit_way = WIX_W'(i);
			if (empty_vec[i]) empty_way = WIX_W'(i);
		end
		// oldest line, ties to the higher way
		oldest = '0;
		victim = '0;
		for (int i = 0; i < MAX_WAYS; i++) begin
			if (active[i] && row_s1[i].rank >= oldest) begin
				oldest = row_s1[i].rank;
				victim = WIX_W'(i);
			end
		end
		hit = |hit_vec;
		was_valid = hit || !(|empty_vec);
		way = hit ? hit_way : ((|empty_vec) ? empty_way : victim);
		r = row_s1[way].rank;
		for (int i = 0; i < MAX_WAYS; i++) begin
			new_row[i] = row_s1[i];
			if (WIX_W'(i) == way) begin
				new_row[i].valid = 1'b1;
				new_row[i].rank  = '0;
				new_row[i].tag   = tag_s1;
			end else if (active[i] && row_s1[i].valid &&
					(!was_valid || row_s1[i].rank < r)) begin
				new_row[i].rank = row_s1[i].rank + RK_W'(1);
			end
		end
	end

	logic is_access;
	assign is_access = (act_s1 != slc_pkg::ACT_NONE);

	// set memory: one read port, one write port, registered read
	logic              mem_we;
	logic [SIDX_W-1:0] mem_waddr;
	row_t              mem_wdata;

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = set_s1;
		mem_wdata = new_row;
		if (state_q == ST_CLEAR) begin
			mem_we    = 1'b1;
			mem_waddr = clr_q;
			mem_wdata = '0;
		end else if (look_done && is_access) begin
			mem_we = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) set_mem[mem_waddr] <= mem_wdata;
		if (req_acc) row_s1 <= set_mem[set_idx];
	end

	always_ff @(posedge clk) begin
		if (req_acc) begin
			act_s1 <= req.action;
			tag_s1 <= tag_in;
			set_s1 <= set_idx;
		end
		if (look_done) begin
			outcome_q <= (!is_access || hit) ? slc_pkg::OUTC_HIT :
				((|empty_vec) ? slc_pkg::OUTC_FILL : slc_pkg::OUTC_EVICT);
			second_q  <= (act_s1 == slc_pkg::ACT_MODIFY);
		end
	end

	// control, configuration and running counts
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_CLEAR;
			clr_q        <= '0;
			set_bits_q   <= 4'd0;
			block_bits_q <= 5'd0;
			ways_q       <= 4'd1;
			rsp_valid_q  <= 1'b0;
			hits_q       <= '0;
			misses_q     <= '0;
			evicts_q     <= '0;
		end else begin
			if (look_done) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
			if (look_done && is_access) begin
				// modify's store half always hits
				hits_q <= slc_pkg::sat_add(hits_q,
					{1'b0, hit} + {1'b0, act_s1 == slc_pkg::ACT_MODIFY});
				misses_q <= slc_pkg::sat_add(misses_q, {1'b0, !hit});
				evicts_q <= slc_pkg::sat_add(evicts_q, {1'b0, !hit && !(|empty_vec)});
			end
			if (cfg_hit) begin
				state_q <= ST_CLEAR;
				clr_q   <= '0;
				unique case (cfg.index)
					slc_pkg::REG_SET_BITS:   set_bits_q   <= cfg.data[3:0];
					slc_pkg::REG_BLOCK_BITS: block_bits_q <= cfg.data[4:0];
					default:                 ways_q       <= cfg.data[3:0];
				endcase
			end else begin
				unique case (state_q)
					ST_CLEAR: begin
						if (clr_q == SIDX_W'(MAX_SETS - 1)) begin
							state_q <= ST_IDLE;
						end
						clr_q <= clr_q + SIDX_W'(1);
					end
					ST_IDLE: begin
						if (req_acc) state_q <= ST_LOOK;
					end
					ST_LOOK: begin
						if (look_done) state_q <= ST_IDLE;
					end
					default: state_q <= ST_CLEAR;
				endcase
			end
		end
	end

	assign rsp.valid           = rsp_valid_q;
	assign rsp.outcome         = outcome_q;
	assign rsp.second_hit      = second_q;
	assign rsp.total_hits      = hits_q;
	assign rsp.total_misses    = misses_q;
	assign rsp.total_evictions = evicts_q;

endmodule

@@ sv/slc_checker.sv @@
// slc_checker: port-level assertions for set_assoc_lru_cache_sim, attached by bind.
// Depends on slc_pkg for codes.
module slc_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         req_ready,
	input logic                         cfg_valid,
	input logic                         cfg_ready,
	input logic [slc_pkg::CIDX_W-1:0]   cfg_index,
	input logic                         rsp_valid,
	input logic                         rsp_ready,
	input logic [slc_pkg::OUTC_W-1:0]   outcome,
	input logic                         second_hit,
	input logic [slc_pkg::CNT_W-1:0]    total_hits,
	input logic [slc_pkg::CNT_W-1:0]    total_misses,
	input logic [slc_pkg::CNT_W-1:0]    total_evictions
);

	// a register write starts a clearing pass
	a_cfg_clears: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid && cfg_ready && (cfg_index == slc_pkg::REG_SET_BITS ||
		cfg_index == slc_pkg::REG_BLOCK_BITS || cfg_index == slc_pkg::REG_WAYS)
		|=> !req_ready)
		else $error("access taken right after a register write");

	a_miss_counted: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && outcome != slc_pkg::OUTC_HIT |-> total_misses != '0)
		else $error("miss reported with zero miss count");

	a_evict_counted: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && outcome == slc_pkg::OUTC_EVICT |-> total_evictions != '0)
		else $error("eviction reported with zero eviction count");

	a_second_counted: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && second_hit |-> total_hits != '0)
		else $error("store half hit with zero hit count");

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(total_hits) &&
		$stable(total_misses) && $stable(total_evictions))
		else $error("result word changed while stalled");

endmodule

bind set_assoc_lru_cache_sim slc_checker u_slc_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.req_ready       (req.ready),
	.cfg_valid       (cfg.valid),
	.cfg_ready       (cfg.ready),
	.cfg_index       (cfg.index),
	.rsp_valid       (rsp.valid),
	.rsp_ready       (rsp.ready),
	.outcome         (rsp.outcome),
	.second_hit      (rsp.second_hit),
	.total_hits      (rsp.total_hits),
	.total_misses    (rsp.total_misses),
	.total_evictions (rsp.total_evictions)
);

@@ sim/tb_set_assoc_lru_cache_sim.sv @@
// tb_set_assoc_lru_cache_sim: self-checking bench for the set-associative LRU cache simulator.
// Depends on slc_pkg, the channel interfaces in slc_ifs.sv and set_assoc_lru_cache_sim.
// Directed accesses come first, then random trace phases under varied cache shapes.
module tb_set_assoc_lru_cache_sim;

	localparam int LINE_COUNT    = slc_pkg::MAX_SETS_DEF * slc_pkg::MAX_WAYS_DEF;
	// floor(log2(MAX_SETS)): the widest set index the block can honour
	localparam int SET_BITS_CAP  = $clog2(slc_pkg::MAX_SETS_DEF + 1) - 1;
	localparam int CFG_SETTLE    = 4;       // idle cycles before a register write
	localparam int END_SETTLE    = 16;      // quiet cycles after the last result word
	localparam int PHASES        = 10;
	localparam int PHASE_WORDS   = 115;
	localparam int POOL_MAX      = 12;
	localparam int PRINT_CAP     = 50;
	localparam logic [slc_pkg::CIDX_W-1:0] REG_UNUSED = 2'd3;

	// receiver behaviour, picked at random by the receiver process
	typedef enum int {RX_FREE, RX_PATTERN, RX_RANDOM, RX_HOLD} rx_mode_t;

	// one expected result word
	typedef struct packed {
		logic [slc_pkg::OUTC_W-1:0] outcome;
		logic                       second_hit;
		logic [slc_pkg::CNT_W-1:0]  hits;
		logic [slc_pkg::CNT_W-1:0]  misses;
		logic [slc_pkg::CNT_W-1:0]  evictions;
	} access_report_t;

	logic clk = 1'b0;
	logic arst_n;

	slc_req_if req_ch();
	slc_rsp_if rsp_ch();
	slc_cfg_if cfg_ch();

	set_assoc_lru_cache_sim u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch),
		.cfg    (cfg_ch)
	);

	always #4 clk = ~clk;

	// ---------------------------------------------------------------------------------------
	// Predictor state: our own copy of the tag store and the registers.
	// way_age: 0 = most recently used, larger = older.
	// ---------------------------------------------------------------------------------------
	logic [31:0]               way_tag  [LINE_COUNT];
	logic                      way_live [LINE_COUNT];
	logic [2:0]                way_age  [LINE_COUNT];
	logic [slc_pkg::CNT_W-1:0] seen_hits, seen_misses, seen_evictions;
	logic [3:0]                cur_set_bits;
	logic [4:0]                cur_block_bits;
	logic [3:0]                cur_ways;

	access_report_t pending_reports[$];
	int unsigned    err_count = 0;

	// sender burst state
	int unsigned burst_left  = 0;
	bit          sender_idle = 1'b1;

	// receiver stall state
	rx_mode_t    rx_mode    = RX_FREE;
	logic [31:0] rx_pattern = 32'h1;
	int unsigned rx_cycle   = 0;
	int unsigned rx_hold    = 0;

	function automatic int unsigned live_set_bits();
		return (cur_set_bits < SET_BITS_CAP) ? cur_set_bits : SET_BITS_CAP;
	endfunction

	function automatic int unsigned live_ways();
		if (cur_ways == 4'd0)
			return 1;
		return (cur_ways > slc_pkg::MAX_WAYS_DEF) ? slc_pkg::MAX_WAYS_DEF : cur_ways;
	endfunction

	function automatic logic [slc_pkg::CNT_W-1:0] bump(input logic [slc_pkg::CNT_W-1:0] v);
		return (v == {slc_pkg::CNT_W{1'b1}}) ? v : v + 1'b1;
	endfunction

	// Make way w the youngest; live ways younger than it (or all of them on a fill) age by one.
	function automatic void promote_way(input int unsigned base, input int unsigned nw,
			input int unsigned w, input logic was_live);
		logic [2:0] pivot;
		int unsigned i;
		pivot = way_age[base + w];
		for (i = 0; i < nw; i++) begin
			if (i != w && way_live[base + i] && (!was_live || way_age[base + i] < pivot))
				way_age[base + i] = way_age[base + i] + 3'd1;
		end
		way_age[base + w] = 3'd0;
	endfunction

	// One cache access against set set_idx: hit, fill of the lowest empty way, or eviction.
	function automatic logic [slc_pkg::OUTC_W-1:0] cache_lookup(input int unsigned set_idx,
			input logic [31:0] tag);
		int unsigned nw, base, victim, i;
		logic [2:0] oldest;
		nw = live_ways();
		base = set_idx * slc_pkg::MAX_WAYS_DEF;
		victim = 0;
		oldest = 3'd0;
		for (i = 0; i < nw; i++) begin
			if (way_live[base + i] && way_tag[base + i] == tag) begin
				seen_hits = bump(seen_hits);
				promote_way(base, nw, i, 1'b1);
				return slc_pkg::OUTC_HIT;
			end
		end
		seen_misses = bump(seen_misses);
		for (i = 0; i < nw; i++) begin
			if (!way_live[base + i]) begin
				way_tag[base + i] = tag;
				promote_way(base, nw, i, 1'b0);
				way_live[base + i] = 1'b1;
				return slc_pkg::OUTC_FILL;
			end
		end
		// ties go to the highest way
		for (i = 0; i < nw; i++) begin
			if (way_age[base + i] >= oldest) begin
				oldest = way_age[base + i];
				victim = i;
			end
		end
		seen_evictions = bump(seen_evictions);
		way_tag[base + victim] = tag;
		promote_way(base, nw, victim, 1'b1);
		return slc_pkg::OUTC_EVICT;
	endfunction

	// Expected result word for one accepted access word.
	function automatic access_report_t score_access(input logic [slc_pkg::ACT_W-1:0] act,
			input logic [slc_pkg::ADDR_W-1:0] addr);
		access_report_t r;
		int unsigned sb, shift, set_idx;
		logic [63:0] wide, set_part, tag_part;
		sb = live_set_bits();
		shift = sb + cur_block_bits;
		wide = {32'd0, addr};
		set_part = (wide >> cur_block_bits) & ((64'd1 << sb) - 64'd1);
		// shift may pass 31: the tag is then zero
		tag_part = wide >> shift;
		set_idx = set_part[15:0];
		r.outcome = slc_pkg::OUTC_HIT;
		r.second_hit = 1'b0;
		if (act != slc_pkg::ACT_NONE) begin
			r.outcome = cache_lookup(set_idx, tag_part[31:0]);
			if (act == slc_pkg::ACT_MODIFY) begin
				// store half of a modify: same line, so always a hit
				void'(cache_lookup(set_idx, tag_part[31:0]));
				r.second_hit = 1'b1;
			end
		end
		r.hits = seen_hits;
		r.misses = seen_misses;
		r.evictions = seen_evictions;
		return r;
	endfunction

	// Register write as the block sees it; any known index drops every line.
	function automatic void apply_register(input logic [slc_pkg::CIDX_W-1:0] idx,
			input logic [slc_pkg::CDATA_W-1:0] val);
		int unsigned i;
		case (idx)
			slc_pkg::REG_SET_BITS:   cur_set_bits = val[3:0];
			slc_pkg::REG_BLOCK_BITS: cur_block_bits = val[4:0];
			slc_pkg::REG_WAYS:       cur_ways = val[3:0];
			default:                 return;
		endcase
		for (i = 0; i < LINE_COUNT; i++) begin
			way_live[i] = 1'b0;
			way_age[i] = 3'd0;
		end
	endfunction

	// Build an address from tag, set and offset under the current shape.
	function automatic logic [slc_pkg::ADDR_W-1:0] compose_address(input logic [31:0] tag,
			input int unsigned set_idx, input logic [31:0] off);
		int unsigned sb;
		logic [63:0] wide;
		sb = live_set_bits();
		wide = ({32'd0, tag} << (sb + cur_block_bits))
			| ((64'(set_idx) & ((64'd1 << sb) - 64'd1)) << cur_block_bits)
			| ({32'd0, off} & ((64'd1 << cur_block_bits) - 64'd1));
		return wide[slc_pkg::ADDR_W-1:0];
	endfunction

	// ---------------------------------------------------------------------------------------
	// Channel drivers. Inputs change only at rising edges (nonblocking); ready is sampled at
	// the falling edge, so a word seen valid and ready there is taken at the next rising edge.
	// Every task returns at a rising edge.
	// ---------------------------------------------------------------------------------------
	task automatic send_access(input logic [slc_pkg::ACT_W-1:0] act,
			input logic [slc_pkg::ADDR_W-1:0] addr);
		int unsigned gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 12);
			gap = 0;
			if (sender_idle)
				gap = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 24) : $urandom_range(0, 3);
			// valid stays high across a zero gap
			if (gap != 0) begin
				req_ch.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		req_ch.valid <= 1'b1;
		req_ch.action <= act;
		req_ch.address <= addr;
		@(negedge clk);
		while (!req_ch.ready)
			@(negedge clk);
		@(posedge clk);
		pending_reports.push_back(score_access(act, addr));
	endtask

	// Hold the sender off until every expected result word has come back.
	task automatic drain_results();
		req_ch.valid <= 1'b0;
		while (pending_reports.size() != 0)
			@(negedge clk);
		@(posedge clk);
	endtask

	// Register writes happen only with the block idle.
	task automatic write_register(input logic [slc_pkg::CIDX_W-1:0] idx,
			input logic [slc_pkg::CDATA_W-1:0] val);
		drain_results();
		repeat (CFG_SETTLE) @(posedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data <= val;
		@(negedge clk);
		while (!cfg_ch.ready)
			@(negedge clk);
		@(posedge clk);
		apply_register(idx, val);
		cfg_ch.valid <= 1'b0;
	endtask

	task automatic program_cache(input logic [slc_pkg::CDATA_W-1:0] sb,
			input logic [slc_pkg::CDATA_W-1:0] bb, input logic [slc_pkg::CDATA_W-1:0] wy);
		write_register(slc_pkg::REG_SET_BITS, sb);
		write_register(slc_pkg::REG_BLOCK_BITS, bb);
		write_register(slc_pkg::REG_WAYS, wy);
	endtask

	// ---------------------------------------------------------------------------------------
	// Receiver: free-running, fixed rotating pattern, random, or long holds.
	// ---------------------------------------------------------------------------------------
	always @(posedge clk) begin
		rx_cycle = rx_cycle + 1;
		if (rx_cycle % 200 == 0) begin
			rx_mode = rx_mode_t'($urandom_range(0, 3));
			rx_pattern = $urandom | 32'h1;
		end
		case (rx_mode)
			RX_FREE:    rsp_ch.ready <= 1'b1;
			RX_PATTERN: rsp_ch.ready <= rx_pattern[rx_cycle[4:0]];
			RX_RANDOM:  rsp_ch.ready <= ($urandom_range(0, 3) != 0);
			default: begin
				if (rx_hold != 0) begin
					rx_hold = rx_hold - 1;
					rsp_ch.ready <= 1'b0;
				end else begin
					rsp_ch.ready <= 1'b1;
					if ($urandom_range(0, 7) == 0)
						rx_hold = $urandom_range(4, 24);
				end
			end
		endcase
	end

	// ---------------------------------------------------------------------------------------
	// Result checker: each taken result word against the oldest expectation.
	// ---------------------------------------------------------------------------------------
	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		err_count++;
		if (err_count <= PRINT_CAP)
			$display("%0t: %s got %0h, wanted %0h", $time, what, got, want);
	endtask

	always @(negedge clk) begin
		access_report_t want;
		if (arst_n === 1'b1 && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
			if (pending_reports.size() == 0) begin
				report_mismatch("result word with none pending, outcome",
					32'(rsp_ch.outcome), 32'd0);
			end else begin
				want = pending_reports.pop_front();
				if (rsp_ch.outcome !== want.outcome)
					report_mismatch("outcome", 32'(rsp_ch.outcome), 32'(want.outcome));
				if (rsp_ch.second_hit !== want.second_hit)
					report_mismatch("second_hit", 32'(rsp_ch.second_hit),
						32'(want.second_hit));
				if (rsp_ch.total_hits !== want.hits)
					report_mismatch("total_hits", rsp_ch.total_hits, want.hits);
				if (rsp_ch.total_misses !== want.misses)
					report_mismatch("total_misses", rsp_ch.total_misses, want.misses);
				if (rsp_ch.total_evictions !== want.evictions)
					report_mismatch("total_evictions", rsp_ch.total_evictions, want.evictions);
			end
		end
	end

	// ---------------------------------------------------------------------------------------
	// Tests
	// ---------------------------------------------------------------------------------------

	// Reset shape: one set, one way, tag is the whole address. Includes the unused action.
	task automatic test_reset_defaults();
		send_access(slc_pkg::ACT_LOAD, 32'h0000_0000);      // fill
		send_access(slc_pkg::ACT_LOAD, 32'h0000_0000);      // hit
		send_access(slc_pkg::ACT_STORE, 32'hFFFF_FFFF);     // evict
		send_access(slc_pkg::ACT_MODIFY, 32'hFFFF_FFFF);    // hit, then hit
		send_access(slc_pkg::ACT_NONE, 32'h1234_5678);      // ignored, counts unchanged
		send_access(slc_pkg::ACT_MODIFY, 32'h0000_0001);    // evict, then hit
		send_access(slc_pkg::ACT_LOAD, 32'hAAAA_5555);      // evict
	endtask

	// Register extremes: widest shape, clamped set bits, offset swallowing the tag, ways 0
	// and ways above the maximum, and a write to the unused index (no flush).
	task automatic test_config_extremes();
		program_cache(5'd8, 5'd24, 5'd8);
		send_access(slc_pkg::ACT_LOAD, 32'hFFFF_FFFF);      // set ff, tag 0: fill
		send_access(slc_pkg::ACT_LOAD, 32'hFF00_0000);      // same line: hit
		send_access(slc_pkg::ACT_STORE, 32'h00FF_FFFF);     // set 0: fill
		send_access(slc_pkg::ACT_MODIFY, 32'h0000_0000);    // hit twice
		program_cache(5'd15, 5'd31, 5'h1F);        // set bits clamp, ways 15 acts as maximum
		send_access(slc_pkg::ACT_LOAD, 32'h8000_0000);      // set 1, tag 0
		send_access(slc_pkg::ACT_LOAD, 32'h7FFF_FFFF);      // set 0, tag 0
		program_cache(5'd0, 5'd0, 5'd0);           // ways 0 acts as one
		send_access(slc_pkg::ACT_LOAD, 32'h0000_0005);
		send_access(slc_pkg::ACT_LOAD, 32'h0000_0006);      // evicts the previous line
		write_register(REG_UNUSED, 5'h1F);
		send_access(slc_pkg::ACT_LOAD, 32'h0000_0006);      // still present: hit
	endtask

	// LRU ordering within a four-way set.
	task automatic test_lru_order();
		program_cache(5'd1, 5'd4, 5'd4);
		send_access(slc_pkg::ACT_LOAD, compose_address(32'd1, 0, 32'h0));
		send_access(slc_pkg::ACT_LOAD, compose_address(32'd2, 0, 32'h3));
		send_access(slc_pkg::ACT_LOAD, compose_address(32'd3, 0, 32'h7));
		send_access(slc_pkg::ACT_LOAD, compose_address(32'd4, 0, 32'hF));
		send_access(slc_pkg::ACT_LOAD, compose_address(32'd1, 0, 32'h1));   // hit, tag 1 youngest
		send_access(slc_pkg::ACT_STORE, compose_address(32'd5, 0, 32'h0));  // evicts tag 2
		send_access(slc_pkg::ACT_LOAD, compose_address(32'd2, 0, 32'h0));   // evicts tag 3
		send_access(slc_pkg::ACT_MODIFY, compose_address(32'd1, 0, 32'h0)); // hit twice
		send_access(slc_pkg::ACT_LOAD, compose_address(32'd3, 1, 32'h0));   // other set: fill
	endtask

	// Random trace phases. Most words reuse a small tag pool over a few sets so that hits,
	// fills and evictions all occur; the rest are full-range addresses and unused actions.
	task automatic test_random_traffic();
		int unsigned phase, n, pool_n, nsets, set_hi, set_idx, roll, i;
		logic [31:0] tag_pool [POOL_MAX];
		logic [slc_pkg::ACT_W-1:0] act;
		logic [slc_pkg::ADDR_W-1:0] addr;
		for (phase = 0; phase < PHASES; phase++) begin
			case (phase)
				0: program_cache(5'd8, 5'd24, 5'd8);
				1: program_cache(5'd0, 5'd0, 5'd1);
				default: program_cache(
					5'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 31) : $urandom_range(0, 8)),
					5'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 31) : $urandom_range(0, 8)),
					5'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 31) : $urandom_range(1, 8)));
			endcase
			// some phases run the sender flat out
			sender_idle = (phase % 4 != 2);
			pool_n = live_ways() + $urandom_range(0, 3);
			for (i = 0; i < POOL_MAX; i++)
				tag_pool[i] = $urandom;
			nsets = 1 << live_set_bits();
			set_hi = (nsets - 1 < 3) ? nsets - 1 : 3;
			for (n = 0; n < PHASE_WORDS; n++) begin
				if (phase == 4 && n == PHASE_WORDS / 2)
					drain_results();
				roll = $urandom_range(0, 19);
				act = 2'($urandom_range(0, 2));
				if (roll == 0) begin
					act = 2'($urandom_range(0, 3));
					addr = $urandom;
				end else if (roll < 3) begin
					addr = $urandom;
				end else begin
					set_idx = ($urandom_range(0, 9) == 0) ? $urandom_range(0, nsets - 1)
						: $urandom_range(0, set_hi);
					addr = compose_address(tag_pool[$urandom_range(0, pool_n - 1)], set_idx,
						$urandom);
				end
				send_access(act, addr);
			end
		end
	endtask

	// ---------------------------------------------------------------------------------------
	// Sequence
	// ---------------------------------------------------------------------------------------
	initial begin
		int unsigned i;
		arst_n = 1'b0;
		req_ch.valid = 1'b0;
		req_ch.action = slc_pkg::ACT_LOAD;
		req_ch.address = '0;
		rsp_ch.ready = 1'b0;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = slc_pkg::REG_SET_BITS;
		cfg_ch.data = '0;
		// predictor after reset
		for (i = 0; i < LINE_COUNT; i++) begin
			way_tag[i] = '0;
			way_live[i] = 1'b0;
			way_age[i] = 3'd0;
		end
		seen_hits = '0;
		seen_misses = '0;
		seen_evictions = '0;
		cur_set_bits = 4'd0;
		cur_block_bits = 5'd0;
		cur_ways = 4'd1;

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_defaults();
		test_config_extremes();
		test_lru_order();
		test_random_traffic();

		drain_results();
		repeat (END_SETTLE) @(posedge clk);
		if (err_count == 0 && pending_reports.size() == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

	// Watchdog: ends the run with an error line if the sequence has not finished.
	initial begin
		#4000000;
		$display("DONE: errors detected");
		$finish;
	end

endmodule
